// File: src/tplu_pkg.sv
// Shared types and constants for the two-level page table updater.
package tplu_pkg;

  localparam int unsigned IdxW  = 10;
  localparam int unsigned PageW = 20;

  localparam logic [31:0] KeepMask  = 32'h0000_0FF8;
  localparam logic [31:0] FrameMask = 32'hFFFF_F000;
  localparam logic [11:0] PdeFlags  = 12'h007;

  typedef enum logic {
    CMD_MAP   = 1'b0,
    CMD_UNMAP = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_FREE    = 2'd1,
    ST_OUTSIDE    = 2'd2,
    ST_NOT_MAPPED = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PDE,
    S_ZERO,
    S_PDE_RD,
    S_PDE_WR,
    S_PTE_RD,
    S_PTE_WR,
    S_UNMAP,
    S_RESP
  } ctrl_state_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] table_root;
    logic [31:0] virtual_address;
    logic [31:0] physical_address;
    logic        writable;
    logic        user_access;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] entry_address;
    logic        table_allocated;
    logic        flush_tlb;
  } res_t;

endpackage

// File: src/two_level_page_table_updater.sv
// Top level of the two-level page table updater.
//
// Channel   Dir  Handshake        Payload
// s_axis    in   tvalid/tready    tuser: cmd; tdata: root, va, pa, writable, user_access
// m_axis    out  tvalid/tready    tdata: status, entry_address, table_allocated, flush_tlb
// cfg       in   we (no stall)    wdata: free_pool_start, reloads free-page pointer
//
// Map to a present table: directory read, entry read, entry write. Unmap:
// directory read, entry clear. Errors answer from idle or after the directory read.
// A map that allocates a table first zeroes the 1024-word table through the single
// memory port. After reset the memory is cleared one word a cycle, MEM_PAGES*1024
// words; no request is taken then, config writes are.
// A stalled result holds the sequencer in its last step; the output register
// frees the sequencer as soon as the result is loaded.
module two_level_page_table_updater import tplu_pkg::*; #(
  parameter int unsigned MEM_PAGES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [PageW-1:0]  cfg_wdata_i,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // [31:0] table_root, [63:32] virtual_address, [95:64] physical_address,
  // [96] writable, [97] user_access, [103:98] zero
  input  logic [103:0]      s_axis_tdata_i,
  // [0] cmd
  input  logic [0:0]        s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // [1:0] status, [33:2] entry_address, [34] table_allocated, [35] flush_tlb,
  // [39:36] zero
  output logic [39:0]       m_axis_tdata_o
);

  localparam int unsigned AW = $clog2(MEM_PAGES) + IdxW;

  req_t          req;
  res_t          res, res_q;
  logic          res_valid, res_ready;
  logic          out_valid_q;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata, mem_rdata;

  assign req = '{cmd: cmd_e'(s_axis_tuser_i[0]),
                 table_root: s_axis_tdata_i[31:0],
                 virtual_address: s_axis_tdata_i[63:32],
                 physical_address: s_axis_tdata_i[95:64],
                 writable: s_axis_tdata_i[96],
                 user_access: s_axis_tdata_i[97]};

  assign res_ready = !out_valid_q || m_axis_tready_i;

  tplu_ctrl #(
    .MEM_PAGES(MEM_PAGES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_valid_i(s_axis_tvalid_i),
    .req_ready_o(s_axis_tready_o),
    .req_i      (req),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .mem_we_o   (mem_we),
    .mem_addr_o (mem_addr),
    .mem_wdata_o(mem_wdata),
    .mem_rdata_i(mem_rdata)
  );

  tplu_ram #(
    .Width(32),
    .Depth(MEM_PAGES * 1024)
  ) u_page_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, res_q.flush_tlb, res_q.table_allocated,
                            res_q.entry_address, res_q.status};

endmodule

// File: src/tplu_ram.sv
// Generic single-port synchronous RAM with registered read.
module tplu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/tplu_ctrl.sv
// Command sequencer: directory walk, table allocation and entry updates.
module tplu_ctrl import tplu_pkg::*; #(
  parameter int unsigned MEM_PAGES = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [PageW-1:0]                    cfg_wdata_i,
  input  logic                                req_valid_i,
  output logic                                req_ready_o,
  input  req_t                                req_i,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output res_t                                res_o,
  output logic                                mem_we_o,
  output logic [$clog2(MEM_PAGES)+IdxW-1:0]   mem_addr_o,
  output logic [31:0]                         mem_wdata_o,
  input  logic [31:0]                         mem_rdata_i
);

  localparam int unsigned PW    = $clog2(MEM_PAGES);
  localparam int unsigned AW    = PW + IdxW;
  localparam int unsigned Depth = MEM_PAGES * 1024;
  localparam logic [AW-1:0]    LastWord  = AW'(Depth - 1);
  localparam logic [PageW:0]   PageLimit = (PageW + 1)'(MEM_PAGES);
  localparam logic [IdxW-1:0]  LastIdx   = {IdxW{1'b1}};

  ctrl_state_e       state_q, state_d;
  req_t              req_q, req_d;
  logic [PageW-1:0]  pt_page_q, pt_page_d;
  logic [PageW-1:0]  nf_q, nf_d;
  logic              alloc_q, alloc_d;
  status_e           err_q, err_d;
  logic [AW-1:0]     cnt_q, cnt_d;

  logic [PageW-1:0]  pd_in, pd_q, rd_page;
  logic [AW-1:0]     pde_at_in, pde_at, pte_at;
  logic [31:0]       entry_addr;
  logic              rd_present;

  assign pd_in     = req_i.table_root[31:12];
  assign pd_q      = req_q.table_root[31:12];
  assign pde_at_in = {pd_in[PW-1:0], req_i.virtual_address[31:22]};
  assign pde_at    = {pd_q[PW-1:0], req_q.virtual_address[31:22]};
  assign pte_at    = {pt_page_q[PW-1:0], req_q.virtual_address[21:12]};
  assign entry_addr = {pt_page_q, req_q.virtual_address[21:12], 2'b00};
  assign rd_page    = mem_rdata_i[31:12];
  assign rd_present = mem_rdata_i[0];

  function automatic logic page_ok(logic [PageW-1:0] page);
    return {1'b0, page} < PageLimit;
  endfunction

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    pt_page_d   = pt_page_q;
    nf_d        = nf_q;
    alloc_d     = alloc_q;
    err_d       = err_q;
    cnt_d       = cnt_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '{status: ST_OK, entry_address: entry_addr,
                    table_allocated: alloc_q, flush_tlb: 1'b1};
    mem_we_o    = 1'b0;
    mem_addr_o  = pde_at;
    mem_wdata_o = '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we_o   = 1'b1;
        mem_addr_o = cnt_q;
        cnt_d      = cnt_q + AW'(1);
        if (cnt_q == LastWord) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        mem_addr_o  = pde_at_in;
        if (req_valid_i) begin
          req_d   = req_i;
          alloc_d = 1'b0;
          if (page_ok(pd_in)) begin
            state_d = S_PDE;
          end else begin
            err_d   = ST_OUTSIDE;
            state_d = S_RESP;
          end
        end
      end
      S_PDE: begin
        pt_page_d = rd_page;
        if (req_q.cmd == CMD_UNMAP) begin
          if (!rd_present) begin
            err_d   = ST_NOT_MAPPED;
            state_d = S_RESP;
          end else if (!page_ok(rd_page)) begin
            err_d   = ST_OUTSIDE;
            state_d = S_RESP;
          end else begin
            state_d = S_UNMAP;
          end
        end else if (rd_present) begin
          if (page_ok(rd_page)) begin
            state_d = S_PTE_RD;
          end else begin
            err_d   = ST_OUTSIDE;
            state_d = S_RESP;
          end
        end else if (!page_ok(nf_q)) begin
          err_d   = ST_NO_FREE;
          state_d = S_RESP;
        end else begin
          pt_page_d = nf_q;
          nf_d      = nf_q + PageW'(1);
          alloc_d   = 1'b1;
          cnt_d     = '0;
          state_d   = S_ZERO;
        end
      end
      S_ZERO: begin
        mem_we_o   = 1'b1;
        mem_addr_o = {pt_page_q[PW-1:0], cnt_q[IdxW-1:0]};
        cnt_d      = cnt_q + AW'(1);
        if (cnt_q[IdxW-1:0] == LastIdx) begin
          state_d = S_PDE_RD;
        end
      end
      S_PDE_RD: begin
        state_d = S_PDE_WR;
      end
      S_PDE_WR: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = (mem_rdata_i & KeepMask) | {pt_page_q, PdeFlags};
        state_d     = S_PTE_RD;
      end
      S_PTE_RD: begin
        mem_addr_o = pte_at;
        state_d    = S_PTE_WR;
      end
      S_PTE_WR: begin
        mem_addr_o  = pte_at;
        mem_wdata_o = (mem_rdata_i & KeepMask) | (req_q.physical_address & FrameMask)
                    | {29'b0, req_q.user_access, req_q.writable, 1'b1};
        if (res_ready_i) begin
          mem_we_o    = 1'b1;
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_UNMAP: begin
        mem_addr_o = pte_at;
        res_o.table_allocated = 1'b0;
        if (res_ready_i) begin
          mem_we_o    = 1'b1;
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_RESP: begin
        res_o = '{status: err_q, entry_address: '0, table_allocated: 1'b0,
                  flush_tlb: 1'b0};
        if (res_ready_i) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      nf_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      nf_q    <= PageW'(16);
      alloc_q <= 1'b0;
      err_q   <= ST_OK;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      nf_q    <= nf_d;
      alloc_q <= alloc_d;
      err_q   <= err_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    pt_page_q <= pt_page_d;
  end

  a_err_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP) |-> !mem_we_o)
    else $error("memory written on an error response");

  a_alloc_bump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PDE && state_d == S_ZERO && !cfg_we_i)
      |=> nf_q == PageW'($past(nf_q) + PageW'(1)))
    else $error("free pointer not advanced on table allocation");

  a_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ZERO && state_d != S_ZERO) |-> cnt_q[IdxW-1:0] == LastIdx)
    else $error("table zeroing walk ended early");

  a_flush_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.flush_tlb == (res_o.status == ST_OK)))
    else $error("flush request does not match status");

  a_alloc_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PDE_WR) |-> (alloc_q && mem_we_o && mem_wdata_o[0]))
    else $error("directory link without allocation");

endmodule

// File: test/two_level_page_table_updater_tb.sv
// Testbench for the two-level page table updater: directed table and random map/unmap traffic.
module two_level_page_table_updater_tb;
  import tplu_pkg::*;

  localparam int unsigned MemPages   = 256;
  localparam int unsigned MemWords   = MemPages * 1024;
  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned AllocCap   = 100;
  localparam int unsigned PhaseItems = 200;
  localparam int unsigned DirN       = 21;

  localparam req_t NoReq = '{CMD_MAP, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0};
  localparam res_t NoRes = '{ST_OK, 32'h0, 1'b0, 1'b0};

  typedef struct packed {
    bit               is_cfg;
    logic [PageW-1:0] pool;
    req_t             req;
    bit               typed;
    res_t             want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [PageW-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  // [31:0] root, [63:32] va, [95:64] pa, [96] writable, [97] user_access
  logic [103:0] s_axis_tdata_i = '0;
  // [0] cmd
  logic [0:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  // [1:0] status, [33:2] entry_address, [34] table_allocated, [35] flush_tlb
  logic [39:0] m_axis_tdata_o;

  // behavioral copy of the page memory and the free-page pointer
  bit   [31:0]      page_mem [MemWords];
  logic [PageW-1:0] free_next  = 20'd16;

  res_t        pending_res [$];
  int unsigned burst_left = 0;
  int unsigned alloc_cnt  = 0;
  int unsigned rx_cnt     = 0;
  int unsigned err_cnt    = 0;
  int unsigned cycle_cnt  = 0;

  dir_row_t dir_rows [DirN] = '{
    '{1'b0, 20'd0, '{CMD_UNMAP, 32'h0000_1000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0},
      1'b1, '{ST_NOT_MAPPED, 32'h0, 1'b0, 1'b0}},
    '{1'b0, 20'd0, '{CMD_MAP, 32'h0000_1FFF, 32'h0000_0FFF, 32'hFFFF_FFFF, 1'b1, 1'b1},
      1'b1, '{ST_OK, 32'h0001_0000, 1'b1, 1'b1}},
    '{1'b0, 20'd0, '{CMD_MAP, 32'h0000_1000, 32'h003F_F000, 32'h0000_0000, 1'b0, 1'b0},
      1'b1, '{ST_OK, 32'h0001_0FFC, 1'b0, 1'b1}},
    '{1'b0, 20'd0, '{CMD_MAP, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0},
      1'b1, '{ST_OUTSIDE, 32'h0, 1'b0, 1'b0}},
    '{1'b0, 20'd0, '{CMD_UNMAP, 32'h0010_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0},
      1'b1, '{ST_OUTSIDE, 32'h0, 1'b0, 1'b0}},
    '{1'b0, 20'd0, '{CMD_MAP, 32'h000F_F000, 32'hFFC0_0000, 32'h1234_5000, 1'b1, 1'b0},
      1'b1, '{ST_OK, 32'h0001_1000, 1'b1, 1'b1}},
    // directory entry points past the end of memory
    '{1'b0, 20'd0, '{CMD_MAP, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1},
      1'b1, '{ST_OUTSIDE, 32'h0, 1'b0, 1'b0}},
    '{1'b0, 20'd0, '{CMD_UNMAP, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0},
      1'b1, '{ST_OUTSIDE, 32'h0, 1'b0, 1'b0}},
    '{1'b0, 20'd0, '{CMD_UNMAP, 32'h0000_1000, 32'h003F_F000, 32'hFFFF_FFFF, 1'b1, 1'b1},
      1'b1, '{ST_OK, 32'h0001_0FFC, 1'b0, 1'b1}},
    // unmap of an already empty entry
    '{1'b0, 20'd0, '{CMD_UNMAP, 32'h0000_1000, 32'h003F_F000, 32'h0000_0000, 1'b0, 1'b0},
      1'b1, '{ST_OK, 32'h0001_0FFC, 1'b0, 1'b1}},
    '{1'b0, 20'd0, '{CMD_MAP, 32'h000F_F123, 32'hFFFF_F000, 32'hA5A5_A000, 1'b0, 1'b1},
      1'b0, NoRes},
    '{1'b1, 20'd255, NoReq, 1'b0, NoRes},
    '{1'b0, 20'd0, '{CMD_MAP, 32'h0000_1000, 32'h0040_0000, 32'h0000_F000, 1'b1, 1'b1},
      1'b1, '{ST_OK, 32'h000F_F000, 1'b1, 1'b1}},
    // pool exhausted
    '{1'b0, 20'd0, '{CMD_MAP, 32'h0000_1000, 32'h0080_0000, 32'h0000_0000, 1'b0, 1'b0},
      1'b1, '{ST_NO_FREE, 32'h0, 1'b0, 1'b0}},
    '{1'b0, 20'd0, '{CMD_UNMAP, 32'h0000_1000, 32'h0080_0000, 32'h0000_0000, 1'b0, 1'b0},
      1'b1, '{ST_NOT_MAPPED, 32'h0, 1'b0, 1'b0}},
    '{1'b1, 20'hFFFFF, NoReq, 1'b0, NoRes},
    '{1'b0, 20'd0, '{CMD_MAP, 32'h0000_2000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0},
      1'b1, '{ST_NO_FREE, 32'h0, 1'b0, 1'b0}},
    '{1'b1, 20'd0, NoReq, 1'b0, NoRes},
    // new table lands on the directory page itself
    '{1'b0, 20'd0, '{CMD_MAP, 32'h0000_0000, 32'h0140_7000, 32'h0000_0000, 1'b0, 1'b0},
      1'b1, '{ST_OK, 32'h0000_001C, 1'b1, 1'b1}},
    '{1'b0, 20'd0, '{CMD_MAP, 32'h0000_0000, 32'h01C0_0000, 32'h0000_3000, 1'b1, 1'b1},
      1'b0, NoRes},
    '{1'b0, 20'd0, '{CMD_UNMAP, 32'h0000_0000, 32'h0140_7000, 32'h0000_0000, 1'b0, 1'b0},
      1'b0, NoRes}
  };

  two_level_page_table_updater #(
    .MEM_PAGES(MemPages)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic res_t apply_page_cmd(input req_t r);
    logic [PageW-1:0] pd_page;
    logic [PageW-1:0] pt_page;
    logic [PageW-1:0] fresh;
    logic [IdxW-1:0]  dir_idx;
    logic [IdxW-1:0]  tbl_idx;
    logic [31:0]      pde;
    int unsigned      pde_at;
    int unsigned      pte_at;
    res_t             res;
    res = NoRes;
    pd_page = r.table_root[31:12];
    dir_idx = r.virtual_address[31:22];
    tbl_idx = r.virtual_address[21:12];
    if (pd_page >= MemPages) begin
      res.status = ST_OUTSIDE;
      return res;
    end
    pde_at = pd_page * 1024 + dir_idx;
    pde = page_mem[pde_at];
    if (r.cmd == CMD_UNMAP) begin
      if (!pde[0]) begin
        res.status = ST_NOT_MAPPED;
        return res;
      end
      pt_page = pde[31:12];
      if (pt_page >= MemPages) begin
        res.status = ST_OUTSIDE;
        return res;
      end
      page_mem[pt_page * 1024 + tbl_idx] = 32'h0;
    end else begin
      if (!pde[0]) begin
        fresh = free_next;
        if (fresh >= MemPages) begin
          res.status = ST_NO_FREE;
          return res;
        end
        free_next = free_next + 1'b1;
        for (int i = 0; i < 1024; i++) page_mem[fresh * 1024 + i] = 32'h0;
        // re-read: the zeroed page may hold this very directory
        pde = page_mem[pde_at];
        pde = (pde & KeepMask) | {fresh, 12'h0} | {20'h0, PdeFlags};
        page_mem[pde_at] = pde;
        res.table_allocated = 1'b1;
      end
      pt_page = pde[31:12];
      if (pt_page >= MemPages) begin
        res.status = ST_OUTSIDE;
        return res;
      end
      pte_at = pt_page * 1024 + tbl_idx;
      page_mem[pte_at] = (page_mem[pte_at] & KeepMask) | (r.physical_address & FrameMask)
                         | {29'h0, r.user_access, r.writable, 1'b1};
    end
    res.entry_address = {pt_page, tbl_idx, 2'b00};
    res.flush_tlb = 1'b1;
    return res;
  endfunction

  task automatic send_req(input req_t r, input bit typed, input res_t want);
    res_t pred;
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'b0, r.user_access, r.writable, r.physical_address,
                        r.virtual_address, r.table_root};
    s_axis_tuser_i  <= r.cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (burst_left == 0) s_axis_tvalid_i <= 1'b0;
    pred = apply_page_cmd(r);
    if (pred.table_allocated) alloc_cnt++;
    pending_res.push_back(typed ? want : pred);
  endtask

  task automatic write_pool(input logic [PageW-1:0] value);
    if (burst_left != 0) begin
      s_axis_tvalid_i <= 1'b0;
      burst_left = 0;
    end
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    free_next  = value;
  endtask

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endtask

  // stimulus
  initial begin
    req_t             r;
    int unsigned      page;
    logic [IdxW-1:0]  dir;
    logic [PageW-1:0] pool_v;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_pool(dir_rows[i].pool);
      else send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       pool_v = 20'd250;
        1:       pool_v = 20'($urandom_range(16, 120));
        2:       pool_v = 20'($urandom_range(256, 20'hFFFFF));
        default: pool_v = 20'($urandom_range(16, 255));
      endcase
      write_pool(pool_v);
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 99) < 8) begin
          r.cmd             = cmd_e'($urandom_range(0, 1));
          r.table_root      = $urandom | 32'h8000_0000;
          r.virtual_address = $urandom;
        end else begin
          r.cmd = ($urandom_range(0, 99) < 65) ? CMD_MAP : CMD_UNMAP;
          // mostly low directory pages; some table pages reused as directories
          page = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 23) : $urandom_range(0, 3);
          r.table_root = {page[19:0], 12'($urandom)};
          case ($urandom_range(0, 7))
            0:       dir = 10'h000;
            1:       dir = 10'h3FF;
            2:       dir = 10'h001;
            3:       dir = 10'h155;
            4:       dir = 10'h2AA;
            5:       dir = 10'h200;
            6:       dir = 10'h0F0;
            default: dir = 10'h00F;
          endcase
          r.virtual_address = {dir, 22'($urandom)};
        end
        r.physical_address = $urandom;
        r.writable         = 1'($urandom_range(0, 1));
        r.user_access      = 1'($urandom_range(0, 1));
        // bound the number of slow table allocations
        if (r.cmd == CMD_MAP && alloc_cnt >= AllocCap && r.table_root[31:12] < MemPages
            && !page_mem[r.table_root[31:12] * 1024 + r.virtual_address[31:22]][0])
          r.cmd = CMD_UNMAP;
        send_req(r, 1'b0, NoRes);
      end
    end

    if (burst_left != 0) s_axis_tvalid_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // result side back-pressure
  initial begin
    bit held;
    held = 1'b0;
    @(posedge clk_i);
    forever begin
      if (!held && rx_cnt >= 150) begin
        held = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (800) @(posedge clk_i);
      end else if ($urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      rx_cnt++;
      if (pending_res.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata_o);
      end else begin
        want = pending_res.pop_front();
        check_field("status", 32'(want.status), 32'(m_axis_tdata_o[1:0]));
        check_field("entry_address", want.entry_address, m_axis_tdata_o[33:2]);
        check_field("table_allocated", 32'(want.table_allocated), 32'(m_axis_tdata_o[34]));
        check_field("flush_tlb", 32'(want.flush_tlb), 32'(m_axis_tdata_o[35]));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule

// File: files.f
src/tplu_pkg.sv
src/tplu_ram.sv
src/tplu_ctrl.sv
src/two_level_page_table_updater.sv
test/two_level_page_table_updater_tb.sv
